[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros for the design files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property checked on every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// antecedent in one cycle, consequent in the next
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[design/bds_pkg.sv]
// ----------------------------------------------------------------------------
// bds_pkg
// types and constants of the 2x2 box downsampler
// ----------------------------------------------------------------------------
package bds_pkg;

  localparam int MaxInWidth    = 2048;
  localparam int MaxComponents = 6;
  localparam int LineDepth     = ((MaxInWidth + 1) / 2) * MaxComponents;

  // fixed widths of the register and sample fields
  localparam int WidthW   = 12;
  localparam int HeightW  = 16;
  localparam int CompsW   = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam int SampleW  = 32;

  // derived widths
  localparam int ColW     = $clog2(MaxInWidth);
  localparam int CompIdxW = (MaxComponents > 1) ? $clog2(MaxComponents) : 1;
  localparam int LineAw   = $clog2(LineDepth);
  localparam int PairW    = SampleW + 1;
  localparam int SumW     = SampleW + 2;

  localparam int ResetWidth  = 512;
  localparam int ResetHeight = 512;
  localparam int ResetComps  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgInWidth    = 2'd0,
    CfgInHeight   = 2'd1,
    CfgComponents = 2'd2
  } cfg_reg_e;

  // effective (clamped) frame geometry
  typedef struct packed {
    logic [WidthW-1:0]  width;
    logic [HeightW-1:0] height;
    logic [CompsW-1:0]  comps;
  } cfg_t;

  // raster position of the next request
  typedef struct packed {
    logic [CompIdxW-1:0] comp;
    logic                odd_col;
    logic                last_col;
    logic                last_comp;
    logic                odd_row;
    logic                last_row;
    logic [LineAw-1:0]   line_idx;
  } pos_t;

endpackage

[design/box_downsample_2x2_top.sv]
// ----------------------------------------------------------------------------
// box_downsample_2x2_top
// 2x2 box filter decimator for an interleaved multi-component raster stream
// ----------------------------------------------------------------------------
//  channel   valid        stall        payload
//  input     in_valid_i   in_stall_o   sample_in_i
//  output    out_valid_o  out_stall_i  sample_out_o, end_of_row_o, end_of_frame_o
//  config    cfg_we_i     -            cfg_idx_i, cfg_wdata_i
//
//  one sample request per clock unless in_stall_o; a completing request loads
//  the middle stage (line store read), then the output register (sum, shift)
//  reset sets the geometry to 512x512 with two components and zeroes the counters
//  the line store is not cleared; an odd row only reads entries of its even row
//  out_stall_i holds the output register; the input stalls only when the
//  middle stage is also full
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module box_downsample_2x2_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bds_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [bds_pkg::CfgDataW-1:0]        cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [bds_pkg::SampleW-1:0]  sample_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [bds_pkg::SampleW-1:0]  sample_out_o,
  output logic                                end_of_row_o,
  output logic                                end_of_frame_o
);
  import bds_pkg::*;

  // configuration
  logic [WidthW-1:0]  in_width_q;
  logic [HeightW-1:0] in_height_q;
  logic [CompsW-1:0]  comps_q;
  logic               cfg_restart;
  cfg_t               cfg_eff;

  assign cfg_restart = cfg_we_i &&
                       (cfg_idx_i inside {CfgInWidth, CfgInHeight, CfgComponents});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_width_q  <= WidthW'(ResetWidth);
      in_height_q <= HeightW'(ResetHeight);
      comps_q     <= CompsW'(ResetComps);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgInWidth:    in_width_q  <= cfg_wdata_i[WidthW-1:0];
        CfgInHeight:   in_height_q <= cfg_wdata_i[HeightW-1:0];
        CfgComponents: comps_q     <= cfg_wdata_i[CompsW-1:0];
        default: ;
      endcase
    end
  end

  // clamp out-of-range geometry
  always_comb begin
    if (in_width_q == '0) begin
      cfg_eff.width = WidthW'(1);
    end else if (in_width_q > WidthW'(MaxInWidth)) begin
      cfg_eff.width = WidthW'(MaxInWidth);
    end else begin
      cfg_eff.width = in_width_q;
    end
    cfg_eff.height = (in_height_q == '0) ? HeightW'(1) : in_height_q;
    if (comps_q == '0) begin
      cfg_eff.comps = CompsW'(1);
    end else if (comps_q > CompsW'(MaxComponents)) begin
      cfg_eff.comps = CompsW'(MaxComponents);
    end else begin
      cfg_eff.comps = comps_q;
    end
  end

  // handshake and pipeline flow
  logic s1_valid_q, out_valid_q;
  logic out_load, accept;

  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_load;
  assign accept     = in_valid_i && !in_stall_o;

  pos_t pos;

  bds_raster_pos u_pos (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_eff),
    .restart_i (cfg_restart),
    .advance_i (accept),
    .pos_o     (pos)
  );

  // horizontal pair
  logic [SampleW-1:0] pair_hold_q [MaxComponents];
  logic [PairW-1:0]   hold_ext, sample_ext, pair;
  logic               complete, store, emit;

  assign hold_ext   = {pair_hold_q[pos.comp][SampleW-1], pair_hold_q[pos.comp]};
  assign sample_ext = {sample_in_i[SampleW-1], sample_in_i};
  assign pair       = pos.odd_col ? hold_ext + sample_ext : sample_ext;
  assign complete   = pos.odd_col || pos.last_col;
  // even rows park the pair sum unless it is the bottom row of an odd height
  assign store      = complete && !pos.odd_row && !pos.last_row;
  assign emit       = complete && (pos.odd_row || pos.last_row);

  always_ff @(posedge clk_i) begin
    if (accept && !pos.odd_col) begin
      pair_hold_q[pos.comp] <= sample_in_i;
    end
  end

  logic [PairW-1:0] line_rdata;
  logic             line_en;

  assign line_en = accept && (store || (emit && pos.odd_row));

  bds_line_store u_line (
    .clk_i   (clk_i),
    .en_i    (line_en),
    .we_i    (store),
    .addr_i  (pos.line_idx),
    .wdata_i (pair),
    .rdata_o (line_rdata)
  );

  // middle stage: waits for the line store read
  logic [PairW-1:0] s1_pair_q;
  logic             s1_use_mem_q, s1_eor_q, s1_eof_q;
  logic             eor;

  assign eor = pos.last_col && pos.last_comp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= emit;
    end else if (out_load) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pair_q    <= pair;
      s1_use_mem_q <= pos.odd_row;
      s1_eor_q     <= eor;
      s1_eof_q     <= eor && pos.last_row;
    end
  end

  // output stage: vertical sum and floor divide by four
  logic [PairW-1:0]   upper;
  logic [SumW-1:0]    sum;
  logic [SampleW-1:0] sample_out_q;
  logic               eor_q, eof_q;

  assign upper = s1_use_mem_q ? line_rdata : '0;
  assign sum   = {upper[PairW-1], upper} + {s1_pair_q[PairW-1], s1_pair_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s1_valid_q) begin
      sample_out_q <= sum[SumW-1:2];
      eor_q        <= s1_eor_q;
      eof_q        <= s1_eof_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_out_o   = sample_out_q;
  assign end_of_row_o   = eor_q;
  assign end_of_frame_o = eof_q;

  `ASSERT_PROP(a_stall_needs_s1, clk_i, rst_ni, in_stall_o |-> s1_valid_q, "input stalled with empty middle stage")
  `ASSERT_PROP(a_eof_has_eor, clk_i, rst_ni, (out_valid_o && end_of_frame_o) |-> end_of_row_o, "end of frame without end of row")
  `ASSERT_NEXT(a_s1_moves_out, clk_i, rst_ni, s1_valid_q && out_load, out_valid_o, "middle stage result lost")
  `ASSERT_NEXT(a_idx_row_start, clk_i, rst_ni, accept && !cfg_we_i && pos.last_col && pos.last_comp, pos.line_idx == '0, "line index not cleared at row end")

endmodule

[design/bds_line_store.sv]
// ----------------------------------------------------------------------------
// bds_line_store
// single-port line memory for the horizontal pair sums of an even row
// ----------------------------------------------------------------------------
module bds_line_store (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic                          we_i,
  input  logic [bds_pkg::LineAw-1:0]    addr_i,
  input  logic [bds_pkg::PairW-1:0]     wdata_i,
  output logic [bds_pkg::PairW-1:0]     rdata_o
);
  import bds_pkg::*;

  logic [PairW-1:0] mem [LineDepth];
  logic [PairW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/bds_raster_pos.sv]
// ----------------------------------------------------------------------------
// bds_raster_pos
// column, row, component and line store index counters
// ----------------------------------------------------------------------------
module bds_raster_pos (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bds_pkg::cfg_t cfg_i,
  input  logic          restart_i,
  input  logic          advance_i,
  output bds_pkg::pos_t pos_o
);
  import bds_pkg::*;

  logic [ColW-1:0]     col_q, col_d;
  logic [HeightW-1:0]  row_q, row_d;
  logic [CompIdxW-1:0] comp_q, comp_d;
  logic [LineAw-1:0]   idx_q, idx_d;

  logic last_col, last_row, last_comp, complete;

  assign last_col  = ({1'b0, col_q} + WidthW'(1)) == cfg_i.width;
  assign last_row  = ({1'b0, row_q} + (HeightW + 1)'(1)) == {1'b0, cfg_i.height};
  assign last_comp = ({1'b0, CompsW'(comp_q)} + (CompsW + 1)'(1)) == {1'b0, cfg_i.comps};
  // a pair is complete on an odd column or on a lone last even column
  assign complete  = col_q[0] | last_col;

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    comp_d = comp_q;
    idx_d  = idx_q;
    if (restart_i) begin
      col_d  = '0;
      row_d  = '0;
      comp_d = '0;
      idx_d  = '0;
    end else if (advance_i) begin
      if (complete) begin
        idx_d = (last_col && last_comp) ? '0 : idx_q + LineAw'(1);
      end
      if (last_comp) begin
        comp_d = '0;
        if (last_col) begin
          col_d = '0;
          row_d = last_row ? '0 : row_q + HeightW'(1);
        end else begin
          col_d = col_q + ColW'(1);
        end
      end else begin
        comp_d = comp_q + CompIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      comp_q <= '0;
      idx_q  <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      comp_q <= comp_d;
      idx_q  <= idx_d;
    end
  end

  assign pos_o.comp      = comp_q;
  assign pos_o.odd_col   = col_q[0];
  assign pos_o.last_col  = last_col;
  assign pos_o.last_comp = last_comp;
  assign pos_o.odd_row   = row_q[0];
  assign pos_o.last_row  = last_row;
  assign pos_o.line_idx  = idx_q;

endmodule
